// ===== design/tvss_pkg.sv =====
package tvss_pkg;

    localparam int SAMPLE_RATE_HZ_DEF = 48000;

    localparam int BASE_W     = 24;
    localparam int CV_W       = 16;
    localparam int AMP_W      = 15;
    localparam int DC_W       = 16;
    localparam int OUT_W      = 16;
    localparam int SLEW_W     = 17;
    localparam int DEV_W      = 24;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 24;

    localparam int RAMP_W     = 24;
    localparam int RAMP_SHIFT = 6;
    localparam int FREQ_W     = 27;
    localparam int DEN_W      = 25;
    localparam int CNT_W      = 24;
    localparam int STEP_W     = AMP_W + RAMP_SHIFT + 1;
    localparam int SLEW_FRAC  = 16;

    localparam logic [SLEW_W-1:0] SLEW_ONE   = 17'd65536;
    localparam logic [SLEW_W-1:0] SLEW_RESET = 17'd32768;
    localparam logic [CNT_W-1:0]  PERIOD_MAX = 24'hFFFFFF;

    localparam logic [CFG_IDX_W-1:0] CFG_SLEW_RATIO = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEVIATION  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FREQ,
        ST_PSET,
        ST_PDIV,
        ST_COUNT,
        ST_SSET,
        ST_SDIV,
        ST_UPDATE
    } state_t;

endpackage

// ===== design/triangle_vco_slew_step.sv =====
// Channel  | Handshake            | Payload
// ---------+----------------------+--------------------------------------------------
// in       | in_valid / in_ready  | base_freq, control_voltage, peak_level, dc_shift
// out      | out_valid/ out_ready | sample_out
// cfg      | cfg_we               | cfg_index, cfg_data
//
// in_ready is low from a transfer until its sample is written to the output register, so the
// block takes no new input while one is in work. One shared restoring divider, one quotient bit per
// cycle, computes the period and then the ramp step; a frequency <= 0 skips the period division
// and a zero step count skips the step division.
// Reset clears the sequencer, the ramp, the direction and the deviation, and sets the slew ratio to SLEW_RESET.
// A finished sample waits in the output register; the next one stalls until it is taken.
module triangle_vco_slew_step #(
    parameter int SAMPLE_RATE_HZ = tvss_pkg::SAMPLE_RATE_HZ_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic        [tvss_pkg::BASE_W-1:0]     base_freq,
    input  logic signed [tvss_pkg::CV_W-1:0]       control_voltage,
    input  logic        [tvss_pkg::AMP_W-1:0]      peak_level,
    input  logic signed [tvss_pkg::DC_W-1:0]       dc_shift,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [tvss_pkg::OUT_W-1:0]      sample_out,
    input  logic                                   cfg_we,
    input  logic        [tvss_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic        [tvss_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int NUM    = SAMPLE_RATE_HZ * 256;
    localparam int NUM_W  = $clog2(NUM + 1);
    localparam int DIV_W  = (NUM_W > tvss_pkg::CNT_W) ? NUM_W : tvss_pkg::CNT_W;
    localparam int DCNT_W = $clog2(DIV_W + 1);
    localparam int RAMP_W = tvss_pkg::RAMP_W;
    localparam int DEN_W  = tvss_pkg::DEN_W;
    localparam int CNT_W  = tvss_pkg::CNT_W;
    localparam int FREQ_W = tvss_pkg::FREQ_W;
    localparam int STEP_W = tvss_pkg::STEP_W;
    localparam int SH_W   = RAMP_W - tvss_pkg::RAMP_SHIFT;
    localparam int Y_W    = SH_W + 1;

    tvss_pkg::state_t state_reg, state_next;

    logic                               out_valid_reg, out_valid_next;
    logic signed [tvss_pkg::OUT_W-1:0]  out_reg, out_next;
    logic        [tvss_pkg::SLEW_W-1:0] slew_reg, slew_next;
    logic        [tvss_pkg::DEV_W-1:0]  dev_reg, dev_next;
    logic signed [RAMP_W-1:0]           ramp_reg, ramp_next;
    logic                               falling_reg, falling_next;
    logic        [DCNT_W-1:0]           dcnt_reg, dcnt_next;

    logic        [tvss_pkg::BASE_W-1:0] base_reg, base_next;
    logic signed [tvss_pkg::CV_W-1:0]   cv_reg, cv_next;
    logic        [tvss_pkg::AMP_W-1:0]  amp_reg, amp_next;
    logic signed [tvss_pkg::DC_W-1:0]   dc_reg, dc_next;
    logic signed [FREQ_W-1:0]           freq_reg, freq_next;
    logic        [CNT_W-1:0]            cnt_reg, cnt_next;
    logic        [DIV_W-1:0]            quo_reg, quo_next;
    logic        [DEN_W-1:0]            rem_reg, rem_next;
    logic        [DEN_W-1:0]            den_reg, den_next;

    logic signed [40:0]                 freq_prod;
    logic signed [40:0]                 freq_sh;
    logic signed [FREQ_W-1:0]           freq_calc;
    logic                               freq_pos;
    logic        [CNT_W-1:0]            period;
    logic        [tvss_pkg::SLEW_W-1:0] slew_eff;
    logic        [tvss_pkg::SLEW_W-1:0] slew_fall;
    logic        [tvss_pkg::SLEW_W-1:0] cnt_factor;
    logic        [40:0]                 cnt_prod;
    logic signed [RAMP_W-1:0]           peak24;
    logic                               dir_falling;

    logic        [DEN_W:0]              div_shift;
    logic        [DEN_W:0]              div_diff;
    logic                               div_ge;
    logic        [DEN_W-1:0]            div_rem;
    logic        [DIV_W-1:0]            div_quo;

    logic signed [RAMP_W:0]             ramp_ext;
    logic signed [RAMP_W:0]             peak_ext;
    logic signed [RAMP_W:0]             step_ext;
    logic signed [RAMP_W:0]             ramp_sum;
    logic signed [RAMP_W-1:0]           ramp_new;
    logic signed [Y_W-1:0]              y_sum;
    logic signed [tvss_pkg::OUT_W-1:0]  y_sat;
    logic                               out_free;

    assign in_ready   = (state_reg == tvss_pkg::ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign sample_out = out_reg;

    // frequency = base + deviation * cv / 2^15, floored
    assign freq_prod = $signed({1'b0, dev_reg}) * cv_reg;
    assign freq_sh   = freq_prod >>> 15;
    assign freq_calc = $signed({{(FREQ_W - tvss_pkg::BASE_W){1'b0}}, base_reg})
                     + $signed(freq_sh[FREQ_W-1:0]);
    assign freq_pos  = !freq_reg[FREQ_W-1] && (freq_reg != '0);

    always_comb
    begin
        if (!freq_pos || (quo_reg > DIV_W'(tvss_pkg::PERIOD_MAX)))
        begin
            period = tvss_pkg::PERIOD_MAX;
        end
        else
        begin
            period = quo_reg[CNT_W-1:0];
        end
    end

    assign slew_eff  = (slew_reg > tvss_pkg::SLEW_ONE) ? tvss_pkg::SLEW_ONE : slew_reg;
    assign slew_fall = tvss_pkg::SLEW_ONE - slew_eff;

    assign peak24 = $signed({{(RAMP_W - tvss_pkg::AMP_W - tvss_pkg::RAMP_SHIFT){1'b0}},
                             amp_reg, {tvss_pkg::RAMP_SHIFT{1'b0}}});

    always_comb
    begin
        if (ramp_reg >= peak24)
        begin
            dir_falling = 1'b1;
        end
        else if (ramp_reg <= -peak24)
        begin
            dir_falling = 1'b0;
        end
        else
        begin
            dir_falling = falling_reg;
        end
    end

    assign cnt_factor = dir_falling ? slew_fall : slew_eff;
    assign cnt_prod   = cnt_factor * period;

    // shared restoring divider step
    assign div_shift = {rem_reg, quo_reg[DIV_W-1]};
    assign div_ge    = (div_shift >= {1'b0, den_reg});
    assign div_diff  = div_shift - {1'b0, den_reg};
    assign div_rem   = div_ge ? div_diff[DEN_W-1:0] : div_shift[DEN_W-1:0];
    assign div_quo   = {quo_reg[DIV_W-2:0], div_ge};

    // ramp update and output
    assign ramp_ext = {ramp_reg[RAMP_W-1], ramp_reg};
    assign peak_ext = {peak24[RAMP_W-1], peak24};
    assign step_ext = $signed({{(RAMP_W + 1 - STEP_W){1'b0}}, quo_reg[STEP_W-1:0]});

    always_comb
    begin
        if (!falling_reg)
        begin
            ramp_sum = (cnt_reg == '0) ? peak_ext : (ramp_ext + step_ext);
        end
        else
        begin
            ramp_sum = (cnt_reg == '0) ? -peak_ext : (ramp_ext - step_ext);
        end
    end

    assign ramp_new = ramp_sum[RAMP_W-1:0];
    assign y_sum    = $signed({ramp_new[RAMP_W-1], ramp_new[RAMP_W-1:tvss_pkg::RAMP_SHIFT]})
                    + $signed({{(Y_W - tvss_pkg::DC_W){dc_reg[tvss_pkg::DC_W-1]}}, dc_reg});

    always_comb
    begin
        if (y_sum > Y_W'(32767))
        begin
            y_sat = 16'sh7FFF;
        end
        else if (y_sum < -Y_W'(32768))
        begin
            y_sat = 16'sh8000;
        end
        else
        begin
            y_sat = y_sum[tvss_pkg::OUT_W-1:0];
        end
    end

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        slew_next      = slew_reg;
        dev_next       = dev_reg;
        ramp_next      = ramp_reg;
        falling_next   = falling_reg;
        dcnt_next      = dcnt_reg;
        base_next      = base_reg;
        cv_next        = cv_reg;
        amp_next       = amp_reg;
        dc_next        = dc_reg;
        freq_next      = freq_reg;
        cnt_next       = cnt_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        den_next       = den_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_we)
        begin
            case (cfg_index)
                tvss_pkg::CFG_SLEW_RATIO: slew_next = cfg_data[tvss_pkg::SLEW_W-1:0];
                tvss_pkg::CFG_DEVIATION:  dev_next  = cfg_data[tvss_pkg::DEV_W-1:0];
                default: ;
            endcase
        end

        case (state_reg)
            tvss_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    base_next  = base_freq;
                    cv_next    = control_voltage;
                    amp_next   = peak_level;
                    dc_next    = dc_shift;
                    state_next = tvss_pkg::ST_FREQ;
                end
            end
            tvss_pkg::ST_FREQ:
            begin
                freq_next  = freq_calc;
                state_next = tvss_pkg::ST_PSET;
            end
            tvss_pkg::ST_PSET:
            begin
                if (freq_pos)
                begin
                    quo_next   = DIV_W'(NUM);
                    den_next   = freq_reg[DEN_W-1:0];
                    rem_next   = '0;
                    dcnt_next  = DCNT_W'(DIV_W);
                    state_next = tvss_pkg::ST_PDIV;
                end
                else
                begin
                    state_next = tvss_pkg::ST_COUNT;
                end
            end
            tvss_pkg::ST_PDIV:
            begin
                quo_next  = div_quo;
                rem_next  = div_rem;
                dcnt_next = dcnt_reg - 1'b1;
                if (dcnt_reg == DCNT_W'(1))
                begin
                    state_next = tvss_pkg::ST_COUNT;
                end
            end
            tvss_pkg::ST_COUNT:
            begin
                falling_next = dir_falling;
                cnt_next     = cnt_prod[tvss_pkg::SLEW_FRAC +: CNT_W];
                state_next   = tvss_pkg::ST_SSET;
            end
            tvss_pkg::ST_SSET:
            begin
                if (cnt_reg != '0)
                begin
                    quo_next   = {{(DIV_W - STEP_W){1'b0}}, amp_reg,
                                  {(tvss_pkg::RAMP_SHIFT + 1){1'b0}}};
                    den_next   = {1'b0, cnt_reg};
                    rem_next   = '0;
                    dcnt_next  = DCNT_W'(DIV_W);
                    state_next = tvss_pkg::ST_SDIV;
                end
                else
                begin
                    state_next = tvss_pkg::ST_UPDATE;
                end
            end
            tvss_pkg::ST_SDIV:
            begin
                quo_next  = div_quo;
                rem_next  = div_rem;
                dcnt_next = dcnt_reg - 1'b1;
                if (dcnt_reg == DCNT_W'(1))
                begin
                    state_next = tvss_pkg::ST_UPDATE;
                end
            end
            tvss_pkg::ST_UPDATE:
            begin
                if (out_free)
                begin
                    ramp_next      = ramp_new;
                    out_next       = y_sat;
                    out_valid_next = 1'b1;
                    state_next     = tvss_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tvss_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tvss_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            slew_reg      <= tvss_pkg::SLEW_RESET;
            dev_reg       <= '0;
            ramp_reg      <= '0;
            falling_reg   <= 1'b0;
            dcnt_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            slew_reg      <= slew_next;
            dev_reg       <= dev_next;
            ramp_reg      <= ramp_next;
            falling_reg   <= falling_next;
            dcnt_reg      <= dcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        base_reg <= base_next;
        cv_reg   <= cv_next;
        amp_reg  <= amp_next;
        dc_reg   <= dc_next;
        freq_reg <= freq_next;
        cnt_reg  <= cnt_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
    end

endmodule

// ===== design/tvss_chk.sv =====
module tvss_chk (
    input logic                                   clk,
    input logic                                   rst_n,
    input logic                                   in_valid,
    input logic                                   in_ready,
    input logic        [tvss_pkg::BASE_W-1:0]     base_freq,
    input logic signed [tvss_pkg::CV_W-1:0]       control_voltage,
    input logic        [tvss_pkg::AMP_W-1:0]      peak_level,
    input logic signed [tvss_pkg::DC_W-1:0]       dc_shift,
    input logic                                   out_valid,
    input logic                                   out_ready,
    input logic signed [tvss_pkg::OUT_W-1:0]      sample_out,
    input logic                                   cfg_we,
    input logic        [tvss_pkg::CFG_IDX_W-1:0]  cfg_index,
    input logic        [tvss_pkg::CFG_DATA_W-1:0] cfg_data
);

    // busy after taking a transfer
    a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("in_ready high right after an input transfer");

    // no sample appears the cycle after an input transfer
    a_no_instant_out: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !$rose(out_valid))
        else $error("output produced one cycle after input");

    // a new sample only comes from a busy block
    a_out_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("sample appeared while block was idle");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(sample_out)))
        else $error("stalled output changed");

endmodule

bind triangle_vco_slew_step tvss_chk u_tvss_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .base_freq       (base_freq),
    .control_voltage (control_voltage),
    .peak_level      (peak_level),
    .dc_shift        (dc_shift),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .sample_out      (sample_out),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
);
